// File: rtl/lrs_pkg.sv
// Shared widths, types and state codes of the latency statistics block.
package lrs_pkg;
  localparam int SAMPLE_WIDTH = 40;
  localparam int FRAC_BITS    = 16;
  localparam int MEAN_WIDTH   = SAMPLE_WIDTH + FRAC_BITS;
  localparam int COUNT_WIDTH  = 48;
  localparam int SPREAD_WIDTH = 64;
  localparam int TOTAL_WIDTH  = 64;
  localparam int TALLY_WIDTH  = 32;
  localparam int LEN_WIDTH    = 16;
  localparam int RSUM_WIDTH   = 56;
  localparam int PROD_WIDTH   = 2 * MEAN_WIDTH;
  localparam int STEP_WIDTH   = $clog2(MEAN_WIDTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_MID  = 5'b00100,
    S_MUL  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;
endpackage

// File: rtl/latency_running_statistics.sv
// Top level: running latency statistics with bit-serial divider and multiplier.
//
// Usage:
//   in_*   : one latency sample per item (valid/ready).
//   out_*  : one result item per sample with all current statistics.
//   cfg_*  : write of repeat_length (samples per repeat, 0 acts as 1);
//            write only while no sample is in progress.
// Sequence: once a sample is accepted, the bit-serial restoring divider
// computes the mean update; the shift-add multiply for the spread then runs
// alongside a second division for the repeat average, and the results are
// registered in the final state.
// Busy: a new sample is accepted only after the previous one leaves the final state.
// Reset: count, max, mean, spread, repeat state and totals clear; min goes
// to all ones; repeat_length returns to 1.
// Stall: the result holds in the output register; a new sample may be taken
// meanwhile, and its result waits in the final state until the output
// register is free.
module latency_running_statistics
  import lrs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [LEN_WIDTH-1:0]    cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_WIDTH-1:0] in_sample_ns,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [COUNT_WIDTH-1:0]  out_sample_count,
  output logic [SAMPLE_WIDTH-1:0] out_min_ns,
  output logic [SAMPLE_WIDTH-1:0] out_max_ns,
  output logic [MEAN_WIDTH-1:0]   out_mean_fixed,
  output logic [SPREAD_WIDTH-1:0] out_spread_fixed,
  output logic                    out_repeat_done,
  output logic [SAMPLE_WIDTH-1:0] out_repeat_average_ns,
  output logic [TALLY_WIDTH-1:0]  out_repeats_done,
  output logic [TOTAL_WIDTH-1:0]  out_repeat_average_total
);
  state_t state_r;
  logic [STEP_WIDTH-1:0]   step_r;
  logic [LEN_WIDTH-1:0]    len_r, lenq_r;
  logic [COUNT_WIDTH-1:0]  cnt_r;
  logic [SAMPLE_WIDTH-1:0] min_r, max_r;
  logic [MEAN_WIDTH-1:0]   mean_r, x_r, m1_r, m2_r, dq_r;
  logic [SPREAD_WIDTH-1:0] spread_r;
  logic [RSUM_WIDTH-1:0]   rsum_r;
  logic [LEN_WIDTH-1:0]    pos_r;
  logic [TALLY_WIDTH-1:0]  tally_r;
  logic [TOTAL_WIDTH-1:0]  total_r;
  logic [COUNT_WIDTH-1:0]  rem_r, dvs_r;
  logic [PROD_WIDTH-1:0]   acc_r;
  logic                    neg_r, done_r;

  logic [MEAN_WIDTH-1:0]   x_in, newm, m2_nxt;
  logic [RSUM_WIDTH:0]     rsum_add;
  logic [RSUM_WIDTH-1:0]   rsum_nxt;
  logic [LEN_WIDTH-1:0]    len_eff, pos_inc;
  logic [COUNT_WIDTH:0]    div_t;
  logic                    div_ge;
  logic [COUNT_WIDTH-1:0]  rem_nxt;
  logic [MEAN_WIDTH:0]     mul_sum;
  logic [SPREAD_WIDTH-1:0] prod_sat;
  logic [SPREAD_WIDTH:0]   spread_add;
  logic [TOTAL_WIDTH:0]    total_add;
  logic                    last_step, out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign last_step = (step_r == STEP_WIDTH'(MEAN_WIDTH - 1));
  assign out_free  = !out_valid || out_ready;

  assign x_in     = {in_sample_ns, {FRAC_BITS{1'b0}}};
  assign rsum_add = {1'b0, rsum_r} + (RSUM_WIDTH+1)'(in_sample_ns);
  assign rsum_nxt = rsum_add[RSUM_WIDTH] ? {RSUM_WIDTH{1'b1}} : rsum_add[RSUM_WIDTH-1:0];
  assign len_eff  = (len_r == '0) ? LEN_WIDTH'(1) : len_r;
  assign pos_inc  = pos_r + LEN_WIDTH'(1);

  assign div_t   = {rem_r, dq_r[MEAN_WIDTH-1]};
  assign div_ge  = div_t >= {1'b0, dvs_r};
  assign rem_nxt = div_ge ? COUNT_WIDTH'(div_t - {1'b0, dvs_r}) : div_t[COUNT_WIDTH-1:0];

  assign newm   = neg_r ? mean_r - dq_r : mean_r + dq_r;
  assign m2_nxt = neg_r ? newm - x_r : x_r - newm;

  assign mul_sum  = {1'b0, acc_r[PROD_WIDTH-1:MEAN_WIDTH]} + (m2_r[0] ? {1'b0, m1_r} : '0);
  assign prod_sat = (acc_r[PROD_WIDTH-1:SPREAD_WIDTH+FRAC_BITS] != '0) ? {SPREAD_WIDTH{1'b1}}
                    : acc_r[SPREAD_WIDTH+FRAC_BITS-1:FRAC_BITS];
  assign spread_add = {1'b0, spread_r} + {1'b0, prod_sat};
  assign total_add  = {1'b0, total_r} + (TOTAL_WIDTH+1)'(dq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      step_r    <= '0;
      len_r     <= LEN_WIDTH'(1);
      cnt_r     <= '0;
      min_r     <= '1;
      max_r     <= '0;
      mean_r    <= '0;
      spread_r  <= '0;
      rsum_r    <= '0;
      pos_r     <= '0;
      tally_r   <= '0;
      total_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        len_r <= cfg_data;
      end
      if (out_valid && out_ready && (state_r != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (cnt_r != '1) begin
              cnt_r <= cnt_r + COUNT_WIDTH'(1);
              dvs_r <= cnt_r + COUNT_WIDTH'(1);
            end else begin
              dvs_r <= cnt_r;
            end
            if (in_sample_ns > max_r) max_r <= in_sample_ns;
            if (in_sample_ns < min_r) min_r <= in_sample_ns;
            x_r    <= x_in;
            neg_r  <= x_in < mean_r;
            m1_r   <= (x_in < mean_r) ? mean_r - x_in : x_in - mean_r;
            dq_r   <= (x_in < mean_r) ? mean_r - x_in : x_in - mean_r;
            rem_r  <= '0;
            rsum_r <= rsum_nxt;
            lenq_r <= len_eff;
            done_r <= pos_inc >= len_eff;
            pos_r  <= (pos_inc >= len_eff) ? '0 : pos_inc;
            step_r <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r  <= rem_nxt;
          dq_r   <= {dq_r[MEAN_WIDTH-2:0], div_ge};
          step_r <= step_r + STEP_WIDTH'(1);
          if (last_step) state_r <= S_MID;
        end
        S_MID: begin
          mean_r <= newm;
          m2_r   <= m2_nxt;
          acc_r  <= '0;
          dq_r   <= MEAN_WIDTH'(rsum_r);
          rem_r  <= '0;
          dvs_r  <= COUNT_WIDTH'(lenq_r);
          if (done_r) rsum_r <= '0;
          step_r <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          acc_r  <= {mul_sum, acc_r[MEAN_WIDTH-1:1]};
          m2_r   <= {1'b0, m2_r[MEAN_WIDTH-1:1]};
          rem_r  <= rem_nxt;
          dq_r   <= {dq_r[MEAN_WIDTH-2:0], div_ge};
          step_r <= step_r + STEP_WIDTH'(1);
          if (last_step) state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            spread_r <= spread_add[SPREAD_WIDTH] ? '1 : spread_add[SPREAD_WIDTH-1:0];
            out_spread_fixed <= spread_add[SPREAD_WIDTH] ? '1 : spread_add[SPREAD_WIDTH-1:0];
            if (done_r) begin
              total_r <= total_add[TOTAL_WIDTH] ? '1 : total_add[TOTAL_WIDTH-1:0];
              tally_r <= tally_r + TALLY_WIDTH'(1);
              out_repeat_average_total <= total_add[TOTAL_WIDTH] ? '1
                                          : total_add[TOTAL_WIDTH-1:0];
              out_repeats_done      <= tally_r + TALLY_WIDTH'(1);
              out_repeat_average_ns <= dq_r[SAMPLE_WIDTH-1:0];
            end else begin
              out_repeat_average_total <= total_r;
              out_repeats_done      <= tally_r;
              out_repeat_average_ns <= '0;
            end
            out_repeat_done  <= done_r;
            out_sample_count <= cnt_r;
            out_min_ns       <= min_r;
            out_max_ns       <= max_r;
            out_mean_fixed   <= mean_r;
            out_valid        <= 1'b1;
            state_r          <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// File: rtl/lrs_checker.sv
// Port-level checks for the latency statistics block, bound to the top level.
module lrs_checker
  import lrs_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [COUNT_WIDTH-1:0]  out_sample_count,
  input logic [SAMPLE_WIDTH-1:0] out_min_ns,
  input logic [SAMPLE_WIDTH-1:0] out_max_ns,
  input logic                    out_repeat_done,
  input logic [SAMPLE_WIDTH-1:0] out_repeat_average_ns
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_count))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while busy");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_min_ns <= out_max_ns)
    else $error("min above max");

  a_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_repeat_done |-> out_repeat_average_ns == '0)
    else $error("average without completed repeat");
endmodule

bind latency_running_statistics lrs_checker u_lrs_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_sample_count     (out_sample_count),
  .out_min_ns           (out_min_ns),
  .out_max_ns           (out_max_ns),
  .out_repeat_done      (out_repeat_done),
  .out_repeat_average_ns(out_repeat_average_ns)
);

// File: test/tb.sv
// Self-checking testbench for the running latency statistics block.
module tb;
  import lrs_pkg::*;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0]  count;
    logic [SAMPLE_WIDTH-1:0] min_ns;
    logic [SAMPLE_WIDTH-1:0] max_ns;
    logic [MEAN_WIDTH-1:0]   mean;
    logic [SPREAD_WIDTH-1:0] spread;
    logic                    done;
    logic [SAMPLE_WIDTH-1:0] avg;
    logic [TALLY_WIDTH-1:0]  tally;
    logic [TOTAL_WIDTH-1:0]  total;
  } stats_t;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_WIDTH) - 1;
  localparam logic [63:0] RSUM_MAX = (64'd1 << RSUM_WIDTH) - 1;
  localparam logic [63:0] SAMPLE_MAX = (64'd1 << SAMPLE_WIDTH) - 1;
  localparam int DRAIN_CYCLES = 150;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [LEN_WIDTH-1:0]    cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic [SAMPLE_WIDTH-1:0] in_sample_ns;
  logic                    out_valid;
  logic                    out_ready;
  logic [COUNT_WIDTH-1:0]  out_sample_count;
  logic [SAMPLE_WIDTH-1:0] out_min_ns;
  logic [SAMPLE_WIDTH-1:0] out_max_ns;
  logic [MEAN_WIDTH-1:0]   out_mean_fixed;
  logic [SPREAD_WIDTH-1:0] out_spread_fixed;
  logic                    out_repeat_done;
  logic [SAMPLE_WIDTH-1:0] out_repeat_average_ns;
  logic [TALLY_WIDTH-1:0]  out_repeats_done;
  logic [TOTAL_WIDTH-1:0]  out_repeat_average_total;

  latency_running_statistics DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample_ns(in_sample_ns),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_sample_count(out_sample_count), .out_min_ns(out_min_ns),
    .out_max_ns(out_max_ns), .out_mean_fixed(out_mean_fixed),
    .out_spread_fixed(out_spread_fixed), .out_repeat_done(out_repeat_done),
    .out_repeat_average_ns(out_repeat_average_ns),
    .out_repeats_done(out_repeats_done),
    .out_repeat_average_total(out_repeat_average_total)
  );

  // model state
  logic [63:0] len_reg, n_samples, lo_seen, hi_seen, mean_acc, spread_acc;
  logic [63:0] rep_sum, rep_pos, rep_count, avg_total;

  stats_t expected_stats[$];
  int     errors;
  int     items_sent;
  int     results_seen;
  int     burst_left;
  int     repeats_seen;
  bit     long_hold;

  always #10 clk = ~clk;

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b,
                                          logic [63:0] limit);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, limit}) ? limit : s[63:0];
  endfunction

  function automatic stats_t fold_sample(logic [SAMPLE_WIDTH-1:0] sample);
    logic [63:0]  s, x, m1, m2, q, newm, len, avg;
    logic [127:0] prod, shifted;
    logic [63:0]  incr;
    logic         neg, done;
    stats_t       r;
    s = {24'd0, sample};
    x = s << FRAC_BITS;
    avg = 0;
    done = 0;
    if (n_samples < COUNT_MAX) n_samples = n_samples + 1;
    if (s > hi_seen) hi_seen = s;
    if (s < lo_seen) lo_seen = s;
    neg = x < mean_acc;
    m1 = neg ? mean_acc - x : x - mean_acc;
    q = m1 / n_samples;
    newm = neg ? mean_acc - q : mean_acc + q;
    m2 = neg ? newm - x : x - newm;
    prod = {64'd0, m1} * {64'd0, m2};
    shifted = prod >> FRAC_BITS;
    incr = (shifted[127:64] != 0) ? ALL_ONES : shifted[63:0];
    spread_acc = sat_sum(spread_acc, incr, ALL_ONES);
    mean_acc = newm & ((64'd1 << MEAN_WIDTH) - 1);
    rep_sum = sat_sum(rep_sum, s, RSUM_MAX);
    len = (len_reg == 0) ? 64'd1 : len_reg;
    rep_pos = (rep_pos + 1) & 64'hFFFF;
    if (rep_pos >= len) begin
      done = 1;
      avg = rep_sum / len;
      avg_total = sat_sum(avg_total, avg, ALL_ONES);
      rep_count = (rep_count + 1) & 64'hFFFF_FFFF;
      rep_sum = 0;
      rep_pos = 0;
    end
    r.count = n_samples[COUNT_WIDTH-1:0];
    r.min_ns = lo_seen[SAMPLE_WIDTH-1:0];
    r.max_ns = hi_seen[SAMPLE_WIDTH-1:0];
    r.mean = mean_acc[MEAN_WIDTH-1:0];
    r.spread = spread_acc;
    r.done = done;
    r.avg = avg[SAMPLE_WIDTH-1:0];
    r.tally = rep_count[TALLY_WIDTH-1:0];
    r.total = avg_total;
    return r;
  endfunction

  task automatic send_sample(logic [SAMPLE_WIDTH-1:0] value, bit bursty);
    in_valid <= 1'b1;
    in_sample_ns <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_stats.push_back(fold_sample(value));
    items_sent++;
    if (bursty) begin
      if (burst_left <= 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_repeat_length(logic [LEN_WIDTH-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    len_reg = {48'd0, value};
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SAMPLE_WIDTH-1:0] random_sample();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return SAMPLE_WIDTH'(w[9:0]);
      1: return SAMPLE_WIDTH'(w[19:0]);
      2: return SAMPLE_MAX[SAMPLE_WIDTH-1:0] - SAMPLE_WIDTH'(w[15:0]);
      3: return 40'd1000 + SAMPLE_WIDTH'(w[11:0]);
      default: return w[SAMPLE_WIDTH-1:0];
    endcase
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // check each result item against the oldest prediction
  always @(posedge clk) begin
    stats_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_stats.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item, expected none actual count %h",
                 $time, out_sample_count);
      end else begin
        e = expected_stats.pop_front();
        if (e.done) repeats_seen++;
        check_field("sample_count", 64'(e.count), 64'(out_sample_count));
        check_field("min_ns", 64'(e.min_ns), 64'(out_min_ns));
        check_field("max_ns", 64'(e.max_ns), 64'(out_max_ns));
        check_field("mean_fixed", 64'(e.mean), 64'(out_mean_fixed));
        check_field("spread_fixed", e.spread, out_spread_fixed);
        check_field("repeat_done", 64'(e.done), 64'(out_repeat_done));
        check_field("repeat_average_ns", 64'(e.avg), 64'(out_repeat_average_ns));
        check_field("repeats_done", 64'(e.tally), 64'(out_repeats_done));
        check_field("repeat_average_total", e.total, out_repeat_average_total);
      end
    end
  end

  // receiver stall pattern, with an occasional long hold
  initial begin
    int cyc;
    int mode;
    cyc = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        long_hold = 0;
      end else begin
        cyc++;
        if (cyc % 300 == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic test_extremes();
    send_sample('0, 0);
    send_sample(SAMPLE_MAX[SAMPLE_WIDTH-1:0], 0);
    send_sample('0, 0);
    send_sample(SAMPLE_MAX[SAMPLE_WIDTH-1:0], 0);
    send_sample(40'h55_5555_5555, 0);
    send_sample(40'hAA_AAAA_AAAA, 0);
    send_sample(40'd1, 0);
    send_sample(40'd1, 0);
  endtask

  task automatic test_repeat_lengths();
    int i;
    write_repeat_length(16'd0);
    send_sample(40'd7, 0);
    send_sample(40'd9, 0);
    write_repeat_length(16'd3);
    for (i = 0; i < 6; i++) send_sample(SAMPLE_MAX[SAMPLE_WIDTH-1:0] - SAMPLE_WIDTH'(i), 0);
    write_repeat_length(16'hFFFF);
    for (i = 0; i < 5; i++) send_sample(40'd100 + SAMPLE_WIDTH'(i), 0);
    // lower the length mid-repeat
    write_repeat_length(16'd2);
    send_sample(40'd50, 0);
    send_sample(40'd60, 0);
  endtask

  task automatic test_random_phase(logic [LEN_WIDTH-1:0] len, int n);
    int i;
    write_repeat_length(len);
    burst_left = $urandom_range(1, 12);
    for (i = 0; i < n; i++) send_sample(random_sample(), 1);
  endtask

  task automatic test_backpressure();
    int i;
    wait_drained();
    long_hold = 1;
    for (i = 0; i < 20; i++) send_sample(random_sample(), 0);
  endtask

  task automatic test_drain_pause();
    int i;
    for (i = 0; i < 30; i++) send_sample(random_sample(), 1);
    wait_drained();
    for (i = 0; i < 30; i++) send_sample(random_sample(), 1);
  endtask

  initial begin
    clk = 0;
    rst_n = 0;
    cfg_valid = 0;
    cfg_data = '0;
    in_valid = 0;
    in_sample_ns = '0;
    out_ready = 0;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    repeats_seen = 0;
    long_hold = 0;
    burst_left = 0;
    len_reg = 1;
    n_samples = 0;
    lo_seen = SAMPLE_MAX;
    hi_seen = 0;
    mean_acc = 0;
    spread_acc = 0;
    rep_sum = 0;
    rep_pos = 0;
    rep_count = 0;
    avg_total = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_repeat_lengths();
    test_random_phase(16'd1, 250);
    test_random_phase(16'd5, 300);
    test_random_phase(LEN_WIDTH'($urandom_range(2, 40)), 300);
    test_backpressure();
    test_drain_pause();
    test_random_phase(16'hFFFF, 100);
    test_random_phase(16'd0, 100);
    test_random_phase(16'd3, 200);
    wait_drained();
    $display("Covered %0d samples, %0d results, %0d completed repeats,", items_sent,
             results_seen, repeats_seen);
    $display("repeat lengths 0 to 65535, spread saturation and a long output hold.");
    if (errors == 0) $display("latency_running_statistics test passed");
    else $display("latency_running_statistics test failed");
    $finish;
  end

  initial begin
    #80_000_000;
    $display("latency_running_statistics test failed");
    $finish;
  end
endmodule
